>>> rtl/prsm_pkg.sv
// ----------------------------------------------------------------------------
// prsm_pkg
// Shared types and constants of the prefix rule slot manager.
// ----------------------------------------------------------------------------
package prsm_pkg;

    localparam int PFX_W    = 64;
    localparam int LEN_W    = 8;
    localparam int TIDX_W   = 6;
    localparam int TBL_W    = 8;
    localparam int SLOT_W   = 6;
    localparam int STAT_W   = 3;
    localparam int CFG_IDX_W = 8;

    localparam logic [LEN_W-1:0] MAX_LEN = 8'd128;

    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STAT_W-1:0] ST_DEFAULT  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_RELEASED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_BASE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TABLE = 8'd1;

    localparam logic [TBL_W-1:0] TABLE_BASE_RST    = 8'd10;
    localparam logic [TBL_W-1:0] DEFAULT_TABLE_RST = 8'd254;

    typedef struct packed {
        logic              op;
        logic [PFX_W-1:0]  prefix_hi;
        logic [PFX_W-1:0]  prefix_lo;
        logic [LEN_W-1:0]  prefix_len;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TBL_W-1:0]  table_number;
        logic [SLOT_W-1:0] slot;
    } out_t;

    typedef struct packed {
        logic [PFX_W-1:0]  hi;
        logic [PFX_W-1:0]  lo;
        logic [LEN_W-1:0]  len;
        logic [TIDX_W-1:0] tidx;
    } entry_t;

    typedef struct packed {
        logic              load;
        logic              clr_count;
        logic              idx_zero;
        logic              idx_count;
        logic              idx_inc;
        logic              idx_dec;
        logic              rd_cur;
        logic              rd_prev;
        logic              wr_shift;
        logic              wr_new;
        logic              set_stop;
        logic              set_result;
        logic [STAT_W-1:0] result_code;
        logic              emit;
    } cmd_t;

    typedef struct packed {
        logic is_release;
        logic len_zero;
        logic idx_at_count;
        logic idx_at_stop;
        logic cmp_equal;
        logic cmp_more;
        logic full;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/prefix_rule_slot_manager.sv
// ----------------------------------------------------------------------------
// prefix_rule_slot_manager
// Priority-ordered table of source prefixes with table number allocation.
//
//   channel  direction  handshake        payload
//   in       input      valid / stall    prsm_pkg::in_t
//   out      output     valid / stall    prsm_pkg::out_t
//   cfg      input      valid / ready    index, 8-bit data
//
// One transaction at a time: a release or a default answer goes from decode
// straight to output. A lookup scans the entries one by one, then shifts each
// entry behind the insertion point up by one (one memory read, then one write).
// Reset clears the fill count, so all entries read as empty; no clearing pass.
// A stalled output holds the result; the next input is taken meanwhile.
// ----------------------------------------------------------------------------
module prefix_rule_slot_manager #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  prsm_pkg::in_t                   in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output prsm_pkg::out_t                  out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [prsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prsm_pkg::TBL_W-1:0]      cfg_data
);

    prsm_pkg::cmd_t  cmd;
    prsm_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    prsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    prsm_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> rtl/prsm_ctrl.sv
// ----------------------------------------------------------------------------
// prsm_ctrl
// Sequencer: decode, scan, shift, insert and deliver one transaction.
// ----------------------------------------------------------------------------
module prsm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  prsm_pkg::stat_t  stat,
    output prsm_pkg::cmd_t   cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_CMP     = 4'd3;
    localparam logic [3:0] S_ALLOC   = 4'd4;
    localparam logic [3:0] S_SHREAD  = 4'd5;
    localparam logic [3:0] S_SHWRITE = 4'd6;
    localparam logic [3:0] S_WRNEW   = 4'd7;
    localparam logic [3:0] S_EMIT    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_release)
                begin
                    cmd.clr_count = 1'b1;
                    cmd.set_result = 1'b1;
                    cmd.result_code = prsm_pkg::ST_RELEASED;
                    state_next = S_EMIT;
                end
                else if (stat.len_zero)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_code = prsm_pkg::ST_DEFAULT;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.idx_zero = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.idx_at_count)
                begin
                    cmd.set_stop = 1'b1;
                    state_next = S_ALLOC;
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.cmp_equal)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_code = prsm_pkg::ST_FOUND;
                    state_next = S_EMIT;
                end
                else if (stat.cmp_more)
                begin
                    cmd.set_stop = 1'b1;
                    state_next = S_ALLOC;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_ALLOC:
            begin
                if (stat.full)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_code = prsm_pkg::ST_FULL;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.idx_count = 1'b1;
                    state_next = S_SHREAD;
                end
            end
            S_SHREAD:
            begin
                if (stat.idx_at_stop)
                begin
                    state_next = S_WRNEW;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next = S_SHWRITE;
                end
            end
            S_SHWRITE:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_dec = 1'b1;
                state_next = S_SHREAD;
            end
            S_WRNEW:
            begin
                cmd.wr_new = 1'b1;
                cmd.set_result = 1'b1;
                cmd.result_code = prsm_pkg::ST_INSERTED;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("load outside idle");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("emit while output busy");
    a_shwrite_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHWRITE |-> $past(state_reg) == S_SHREAD)
        else $error("shift write without read");
`endif

endmodule

>>> rtl/prsm_dp.sv
// ----------------------------------------------------------------------------
// prsm_dp
// Entry memory, fill count, prefix compare and result register.
// ----------------------------------------------------------------------------
module prsm_dp #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  prsm_pkg::in_t                       in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output prsm_pkg::out_t                      out_data,
    input  logic                                cfg_valid,
    input  logic [prsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [prsm_pkg::TBL_W-1:0]          cfg_data,
    input  prsm_pkg::cmd_t                      cmd,
    output prsm_pkg::stat_t                     stat
);

    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    prsm_pkg::in_t    item_reg;
    prsm_pkg::entry_t rd_reg;
    prsm_pkg::out_t   res_reg;
    prsm_pkg::out_t   out_reg;
    logic             out_valid_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    idx_reg;
    logic [CW-1:0]    stop_reg;
    logic [prsm_pkg::TBL_W-1:0] table_base_reg;
    logic [prsm_pkg::TBL_W-1:0] default_table_reg;

    prsm_pkg::entry_t ent_mem [NUM_SLOTS];

    logic [CW-1:0]    idx_prev;
    logic [AW-1:0]    rd_addr;
    logic [prsm_pkg::LEN_W-1:0] m_len;
    logic [63:0]      mhi;
    logic [63:0]      mlo;
    logic             v4_new;
    logic             v4_ent;
    logic             match;
    prsm_pkg::entry_t new_ent;

    assign idx_prev = idx_reg - CW'(1);
    assign rd_addr  = cmd.rd_prev ? idx_prev[AW-1:0] : idx_reg[AW-1:0];

    assign new_ent.hi   = item_reg.prefix_hi;
    assign new_ent.lo   = item_reg.prefix_lo;
    assign new_ent.len  = item_reg.prefix_len;
    assign new_ent.tidx = prsm_pkg::TIDX_W'(count_reg);

    always_comb
    begin
        m_len = (item_reg.prefix_len < rd_reg.len) ? item_reg.prefix_len : rd_reg.len;
        if (m_len >= 8'd64)
        begin
            mhi = '1;
        end
        else
        begin
            mhi = ~({64{1'b1}} >> m_len);
        end
        if (m_len <= 8'd64)
        begin
            mlo = '0;
        end
        else if (m_len >= 8'd128)
        begin
            mlo = '1;
        end
        else
        begin
            mlo = ~({64{1'b1}} >> (m_len - 8'd64));
        end
        v4_new = (item_reg.prefix_hi == 64'd0) && (item_reg.prefix_lo[63:32] == 32'hFFFF);
        v4_ent = (rd_reg.hi == 64'd0) && (rd_reg.lo[63:32] == 32'hFFFF);
        match = (v4_new == v4_ent)
             && (((item_reg.prefix_hi ^ rd_reg.hi) & mhi) == 64'd0)
             && (((item_reg.prefix_lo ^ rd_reg.lo) & mlo) == 64'd0);
    end

    assign stat.is_release   = item_reg.op;
    assign stat.len_zero     = (item_reg.prefix_len == '0);
    assign stat.idx_at_count = (idx_reg == count_reg);
    assign stat.idx_at_stop  = (idx_reg == stop_reg);
    assign stat.cmp_equal    = match && (item_reg.prefix_len == rd_reg.len);
    assign stat.cmp_more     = match && (item_reg.prefix_len > rd_reg.len);
    assign stat.full         = (count_reg == CW'(NUM_SLOTS));
    assign stat.out_free     = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg.op         <= in_data.op;
            item_reg.prefix_hi  <= in_data.prefix_hi;
            item_reg.prefix_lo  <= in_data.prefix_lo;
            item_reg.prefix_len <= (in_data.prefix_len > prsm_pkg::MAX_LEN)
                                 ? prsm_pkg::MAX_LEN : in_data.prefix_len;
        end
        if (cmd.rd_cur || cmd.rd_prev)
        begin
            rd_reg <= ent_mem[rd_addr];
        end
        if (cmd.wr_shift)
        begin
            ent_mem[idx_reg[AW-1:0]] <= rd_reg;
        end
        else if (cmd.wr_new)
        begin
            ent_mem[stop_reg[AW-1:0]] <= new_ent;
        end
        if (cmd.set_stop)
        begin
            stop_reg <= idx_reg;
        end
        if (cmd.set_result)
        begin
            res_reg.status <= cmd.result_code;
            case (cmd.result_code)
                prsm_pkg::ST_FOUND:
                begin
                    res_reg.table_number <= table_base_reg
                                          + prsm_pkg::TBL_W'(rd_reg.tidx);
                    res_reg.slot <= prsm_pkg::SLOT_W'(idx_reg);
                end
                prsm_pkg::ST_INSERTED:
                begin
                    res_reg.table_number <= table_base_reg + prsm_pkg::TBL_W'(count_reg);
                    res_reg.slot <= prsm_pkg::SLOT_W'(stop_reg);
                end
                prsm_pkg::ST_DEFAULT:
                begin
                    res_reg.table_number <= default_table_reg;
                    res_reg.slot <= '0;
                end
                default:
                begin
                    res_reg.table_number <= '0;
                    res_reg.slot <= '0;
                end
            endcase
        end
        if (cmd.emit)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            idx_reg           <= '0;
            out_valid_reg     <= 1'b0;
            table_base_reg    <= prsm_pkg::TABLE_BASE_RST;
            default_table_reg <= prsm_pkg::DEFAULT_TABLE_RST;
        end
        else
        begin
            if (cmd.clr_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.wr_new)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.idx_zero)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_count)
            begin
                idx_reg <= count_reg;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_prev;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_index == prsm_pkg::REG_TABLE_BASE)
            begin
                table_base_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == prsm_pkg::REG_DEFAULT_TABLE)
            begin
                default_table_reg <= cfg_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NUM_SLOTS))
        else $error("fill count beyond capacity");
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_new |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow fill count");
    a_stop_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_new |-> stop_reg <= count_reg)
        else $error("insert beyond fill count");
`endif

endmodule

>>> tb/prsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsm_checker
// Watches the input, output and configuration transactions of the prefix
// rule slot manager, predicts each answer from its own copy of the prefix
// table and the allocations, and compares every output transaction in order.
// ----------------------------------------------------------------------------
module prsm_checker #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  prsm_pkg::in_t                   in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  prsm_pkg::out_t                  out_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [prsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prsm_pkg::TBL_W-1:0]      cfg_data,
    output int                              fail_count,
    output int                              answers_pending
);

    logic [prsm_pkg::TBL_W-1:0]  tbl_base;
    logic [prsm_pkg::TBL_W-1:0]  dflt_tbl;
    logic [127:0]                slot_pfx [NUM_SLOTS];
    int                          slot_len [NUM_SLOTS];
    int                          slot_tidx[NUM_SLOTS];
    logic                        tidx_busy[NUM_SLOTS];
    prsm_pkg::out_t              answer_q[$];

    function automatic logic is_v4_mapped(logic [127:0] p);
        return p[127:32] == 96'h0000_0000_0000_0000_0000_FFFF;
    endfunction

    function automatic prsm_pkg::out_t predict_answer(prsm_pkg::in_t t);
        prsm_pkg::out_t r;
        int             ln;
        int             m;
        int             stop;
        int             hole;
        int             tix;
        logic [127:0]   np;
        logic [127:0]   mask;
        r    = '{status: prsm_pkg::ST_FULL, table_number: '0, slot: '0};
        stop = -1;
        hole = -1;
        tix  = -1;
        np   = {t.prefix_hi, t.prefix_lo};
        if (t.op)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_len[i]  = 0;
                tidx_busy[i] = 1'b0;
            end
            r.status = prsm_pkg::ST_RELEASED;
            return r;
        end
        ln = (t.prefix_len > prsm_pkg::MAX_LEN) ? 128 : int'(t.prefix_len);
        if (ln == 0)
        begin
            r.status       = prsm_pkg::ST_DEFAULT;
            r.table_number = dflt_tbl;
            return r;
        end
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (slot_len[i] == 0)
            begin
                stop = i;
                break;
            end
            m    = (ln < slot_len[i]) ? ln : slot_len[i];
            mask = (m == 0) ? '0 : ~128'd0 << (128 - m);
            if (is_v4_mapped(np) == is_v4_mapped(slot_pfx[i])
                && ((np ^ slot_pfx[i]) & mask) == '0)
            begin
                if (ln == slot_len[i])
                begin
                    r.status       = prsm_pkg::ST_FOUND;
                    r.table_number = prsm_pkg::TBL_W'(slot_tidx[i]) + tbl_base;
                    r.slot         = prsm_pkg::SLOT_W'(i);
                    return r;
                end
                if (ln > slot_len[i])
                begin
                    stop = i;
                    break;
                end
            end
        end
        if (stop < 0)
            return r;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (!tidx_busy[i])
            begin
                tix = i;
                break;
            end
        if (tix < 0)
            return r;
        for (int i = stop; i < NUM_SLOTS; i++)
            if (slot_len[i] == 0)
            begin
                hole = i;
                break;
            end
        if (hole < 0)
            for (int i = stop - 1; i >= 0; i--)
                if (slot_len[i] == 0)
                begin
                    hole = i;
                    break;
                end
        if (hole < 0)
            return r;
        if (hole > stop)
            for (int i = hole; i > stop; i--)
            begin
                slot_pfx[i]  = slot_pfx[i-1];
                slot_len[i]  = slot_len[i-1];
                slot_tidx[i] = slot_tidx[i-1];
            end
        else
            for (int i = hole; i < stop; i++)
            begin
                slot_pfx[i]  = slot_pfx[i+1];
                slot_len[i]  = slot_len[i+1];
                slot_tidx[i] = slot_tidx[i+1];
            end
        tidx_busy[tix]  = 1'b1;
        slot_pfx[stop]  = np;
        slot_len[stop]  = ln;
        slot_tidx[stop] = tix;
        r.status        = prsm_pkg::ST_INSERTED;
        r.table_number  = prsm_pkg::TBL_W'(tix) + tbl_base;
        r.slot          = prsm_pkg::SLOT_W'(stop);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        prsm_pkg::out_t want;
        if (!rst_n)
        begin
            tbl_base        <= prsm_pkg::TABLE_BASE_RST;
            dflt_tbl        <= prsm_pkg::DEFAULT_TABLE_RST;
            fail_count      <= 0;
            answers_pending <= 0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_pfx[i]  = '0;
                slot_len[i]  = 0;
                slot_tidx[i] = 0;
                tidx_busy[i] = 1'b0;
            end
            answer_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == prsm_pkg::REG_TABLE_BASE)
                    tbl_base <= cfg_data;
                else if (cfg_index == prsm_pkg::REG_DEFAULT_TABLE)
                    dflt_tbl <= cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (answer_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (out_data.status !== want.status
                        || out_data.table_number !== want.table_number
                        || out_data.slot !== want.slot)
                    begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, want, out_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                answer_q.push_back(predict_answer(in_data));
            answers_pending <= answer_q.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the prefix rule slot manager with directed and random prefix
// transactions under several table settings, with random idle and stall
// cycles, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int SLOTS      = 16;
    localparam int DRAIN_WAIT = 4 * SLOTS + 40;
    localparam int CYCLE_CAP  = 3000000;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    prsm_pkg::in_t                   in_data;
    logic                            out_valid;
    logic                            out_stall;
    prsm_pkg::out_t                  out_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [prsm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [prsm_pkg::TBL_W-1:0]      cfg_data;
    int                              fail_count;
    int                              answers_pending;
    int                              cycles;
    logic                            idle_on;
    logic [127:0]                    pfx_pool[6];

    prefix_rule_slot_manager #(.NUM_SLOTS(SLOTS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    prsm_checker #(.NUM_SLOTS(SLOTS)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .answers_pending (answers_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            cycles    <= 0;
        end
        else
        begin
            out_stall <= idle_on && ($urandom_range(99) < 17);
            cycles    <= cycles + 1;
            if (cycles > CYCLE_CAP)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_item(prsm_pkg::in_t d);
        logic stalled;
        while (idle_on && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        forever
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
            if (!stalled)
                break;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (answers_pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [prsm_pkg::CFG_IDX_W-1:0] idx,
                             logic [prsm_pkg::TBL_W-1:0] val);
        logic ready_seen;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever
        begin
            @(negedge clk);
            ready_seen = cfg_ready;
            @(posedge clk);
            if (ready_seen)
                break;
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic prsm_pkg::in_t make_item(logic op, logic [127:0] p, int len);
        prsm_pkg::in_t d;
        d.op         = op;
        d.prefix_hi  = p[127:64];
        d.prefix_lo  = p[63:0];
        d.prefix_len = prsm_pkg::LEN_W'(len);
        return d;
    endfunction

    function automatic logic [127:0] rand_pfx();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic prsm_pkg::in_t random_item();
        int           pick;
        int           len;
        logic [127:0] p;
        pick = $urandom_range(99);
        if (pick < 3)
            return make_item(1'b1, rand_pfx(), $urandom_range(255));
        if (pick < 6)
            return make_item(1'b0, rand_pfx(), 0);
        if (pick < 16)
            return make_item(1'($urandom_range(1)), rand_pfx(), $urandom_range(255));
        p = pfx_pool[$urandom_range(5)];
        case ($urandom_range(5))
            0: len = 8;
            1: len = 16 * $urandom_range(1, 8);
            2: len = 96 + $urandom_range(32);
            3: len = $urandom_range(1, 40);
            default: len = 4 * $urandom_range(1, 32);
        endcase
        if ($urandom_range(3) == 0)
            p = p ^ (rand_pfx() & (len >= 128 ? '0 : ~128'd0 >> len));
        if ($urandom_range(9) == 0)
            p[$urandom_range(127)] ^= 1'b1;
        return make_item(1'b0, p, len);
    endfunction

    task automatic fill_pool();
        pfx_pool[0] = rand_pfx();
        pfx_pool[1] = rand_pfx();
        pfx_pool[2] = {96'h0000_0000_0000_0000_0000_FFFF, 32'($urandom)};
        pfx_pool[3] = {96'h0000_0000_0000_0000_0000_FFFF, 32'($urandom)};
        pfx_pool[4] = '0;
        pfx_pool[5] = ~128'd0;
    endtask

    task automatic run_directed();
        logic [127:0] v4;
        v4 = {96'h0000_0000_0000_0000_0000_FFFF, 32'hC0A8_0000};
        send_item(make_item(1'b0, '0, 0));
        send_item(make_item(1'b0, ~128'd0, 128));
        send_item(make_item(1'b0, ~128'd0, 200));
        send_item(make_item(1'b0, '0, 1));
        send_item(make_item(1'b0, {1'b0, 127'h5}, 1));
        send_item(make_item(1'b0, v4, 112));
        send_item(make_item(1'b0, {96'd0, 32'hC0A8_0000}, 112));
        send_item(make_item(1'b0, ~128'd0, 64));
        send_item(make_item(1'b1, ~128'd0, 255));
        for (int i = 0; i < SLOTS; i++)
            send_item(make_item(1'b0, {8'(i + 1), 120'd0}, 8));
        send_item(make_item(1'b0, {8'd3, 8'd7, 112'd0}, 16));
        send_item(make_item(1'b0, {8'd200, 120'd0}, 8));
        send_item(make_item(1'b0, {8'd5, 120'h1234}, 8));
        send_item(make_item(1'b1, '0, 0));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        idle_on   = 1'b1;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int phase = 0; phase < 5; phase++)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    write_reg(prsm_pkg::REG_TABLE_BASE, 8'd255);
                    write_reg(prsm_pkg::REG_DEFAULT_TABLE, 8'd0);
                end
                1:
                begin
                    write_reg(prsm_pkg::REG_TABLE_BASE, 8'd0);
                    write_reg(prsm_pkg::REG_DEFAULT_TABLE, 8'd255);
                end
                default:
                begin
                    write_reg(prsm_pkg::REG_TABLE_BASE, 8'($urandom));
                    write_reg(prsm_pkg::REG_DEFAULT_TABLE, 8'($urandom));
                end
            endcase
            fill_pool();
            for (int n = 0; n < 400; n++)
            begin
                idle_on <= !(phase == 2 && n >= 50 && n < 350);
                if (n == 200)
                    wait_drained();
                send_item(random_item());
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (answers_pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
